// ===== rtl/pascal_comment_and_routine_scanner_assert.svh =====
`ifndef PASCAL_COMMENT_AND_ROUTINE_SCANNER_ASSERT_SVH
`define PASCAL_COMMENT_AND_ROUTINE_SCANNER_ASSERT_SVH

// Two conditions never hold together.
`define PCRS_ASSERT_EXCL(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !((a) && (b))) \
    else $error("pcrs: exclusive conditions both true");

// A condition always brings a consequence in the same cycle.
`define PCRS_ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("pcrs: implication violated");

`endif

// ===== rtl/pcrs_pkg.sv =====
package pcrs_pkg;

  // Comment tracker codes
  localparam logic [1:0] CM_SPACE   = 2'd0;
  localparam logic [1:0] CM_START   = 2'd1;
  localparam logic [1:0] CM_END     = 2'd2;
  localparam logic [1:0] CM_COMMENT = 2'd3;

  // Keyword matcher codes
  localparam logic [2:0] KW_CODE  = 3'd0;
  localparam logic [2:0] KW_PROC  = 3'd1;
  localparam logic [2:0] KW_FUNC  = 3'd2;
  localparam logic [2:0] KW_BEGIN = 3'd3;
  localparam logic [2:0] KW_END   = 3'd4;
  localparam logic [2:0] KW_SPACE = 3'd5;
  localparam logic [2:0] KW_NAME  = 3'd6;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 96;

  typedef struct packed {
    logic [15:0] page;
    logic [31:0] char_position;
    logic [7:0]  lookahead_char;
    logic [7:0]  char_code;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] name_page;
    logic [31:0] name_end;
    logic [31:0] name_start;
    logic        name_done;
    logic        name_char;
    logic        routine_end;
    logic        italic;
    logic [7:0]  char_out;
  } out_beat_t;

  // Length of the keyword matched in a given mode
  function automatic logic [3:0] kw_len(input logic [2:0] mode);
    logic [3:0] len;
    case (mode)
      KW_PROC:  len = 4'd9;
      KW_FUNC:  len = 4'd8;
      KW_BEGIN: len = 4'd5;
      KW_END:   len = 4'd3;
      default:  len = 4'd0;
    endcase
    return len;
  endfunction

  // Expected byte at a position of the keyword in a given mode
  function automatic logic [7:0] kw_char(input logic [2:0] mode, input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (mode)
      KW_PROC: begin
        case (idx)
          4'd0: ch = "p";
          4'd1: ch = "r";
          4'd2: ch = "o";
          4'd3: ch = "c";
          4'd4: ch = "e";
          4'd5: ch = "d";
          4'd6: ch = "u";
          4'd7: ch = "r";
          4'd8: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KW_FUNC: begin
        case (idx)
          4'd0: ch = "f";
          4'd1: ch = "u";
          4'd2: ch = "n";
          4'd3: ch = "c";
          4'd4: ch = "t";
          4'd5: ch = "i";
          4'd6: ch = "o";
          4'd7: ch = "n";
          default: ch = 8'h00;
        endcase
      end
      KW_BEGIN: begin
        case (idx)
          4'd0: ch = "b";
          4'd1: ch = "e";
          4'd2: ch = "g";
          4'd3: ch = "i";
          4'd4: ch = "n";
          default: ch = 8'h00;
        endcase
      end
      KW_END: begin
        case (idx)
          4'd0: ch = "e";
          4'd1: ch = "n";
          4'd2: ch = "d";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/pascal_comment_and_routine_scanner.sv =====
// Pascal comment and routine scanner. Takes one source byte per beat with its
// lookahead byte, position and page, and returns one result beat per byte:
// the echoed byte, an italic flag for comment bytes, a flag on the end keyword
// that closes a routine, and the name capture of procedure/function headers
// (start, end and page on the byte after the name). Throughput is one byte per
// clock unless output back-pressure stalls it; a byte passes an input register
// and then a result register, from which its result is presented.
// The scanner state is updated in the single step between those registers,
// which sets the one-byte-per-cycle rate.
// Input ready follows output ready when both registers are full.
module pascal_comment_and_routine_scanner #(
  parameter int unsigned NAME_MAX  = 32,
  parameter int unsigned DEPTH_MAX = 255
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // char_code[7:0], lookahead_char[15:8], char_position[47:16], page[63:48]
  input  logic [pcrs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // restart[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // char_out[7:0], italic[8], routine_end[9], name_char[10], name_done[11],
  // name_start[43:12], name_end[75:44], name_page[91:76], zero[95:92]
  output logic [pcrs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pcrs_pkg::*;

  localparam int unsigned NW = (NAME_MAX > 2) ? $clog2(NAME_MAX) : 1;
  localparam int unsigned DW = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX + 1) : 1;
  localparam int unsigned RW = DW + 1;

  logic              in_valid_q, in_valid_d;
  in_beat_t          in_q;
  logic              restart_q;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;
  logic              advance, step;

  logic [1:0]        cm_q, cm_d;
  logic [2:0]        kw_q, kw_d;
  logic [3:0]        idx_q, idx_d;
  logic [NW-1:0]     nlen_q, nlen_d;
  logic [31:0]       sstart_q, sstart_d;
  logic [15:0]       spage_q, spage_d;
  logic [DW-1:0]     bdepth_q, bdepth_d;
  logic signed [RW-1:0] rdepth_q, rdepth_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign step          = in_valid_q && advance;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = advance ? in_valid_q : out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    logic [7:0] c;
    logic       is_sp, is_al, is_an;
    logic [1:0] cm;
    logic [2:0] kw;
    logic [DW-1:0] bd;
    logic signed [RW-1:0] rd;
    logic [DW-1:0] bd_dec;

    c      = in_q.char_code;
    is_sp  = (c inside {8'h20, [8'h09:8'h0D]});
    is_al  = (c inside {["a":"z"], ["A":"Z"]});
    is_an  = is_al || (c inside {["0":"9"]});
    cm     = restart_q ? CM_SPACE : cm_q;
    kw     = restart_q ? KW_CODE : kw_q;
    bd     = restart_q ? '0 : bdepth_q;
    rd     = restart_q ? '0 : rdepth_q;
    bd_dec = bd - DW'(1);

    out_d          = '0;
    out_d.char_out = c;
    idx_d    = idx_q;
    nlen_d   = nlen_q;
    sstart_d = sstart_q;
    spage_d  = spage_q;
    bdepth_d = bd;
    rdepth_d = rd;
    cm_d     = cm;
    kw_d     = kw;

    case (cm)
      CM_SPACE: begin
        if (!is_sp) begin
          if (c == CH_LBRACE) begin
            cm_d         = CM_COMMENT;
            out_d.italic = 1'b1;
          end else if (c == CH_LPAREN) begin
            out_d.italic = (in_q.lookahead_char == CH_STAR);
            cm_d         = CM_START;
          end
        end
      end
      CM_START: begin
        if (c == CH_STAR) begin
          cm_d         = CM_COMMENT;
          out_d.italic = 1'b1;
        end else begin
          cm_d = CM_SPACE;
        end
      end
      CM_END: begin
        out_d.italic = 1'b1;
        if (c == CH_RPAREN) cm_d = CM_SPACE;
        else if (c != CH_STAR) cm_d = CM_COMMENT;
      end
      default: begin
        out_d.italic = 1'b1;
        if (c == CH_RBRACE) cm_d = CM_SPACE;
        else if (c == CH_STAR) cm_d = CM_END;
      end
    endcase

    // Only bytes that leave the comment tracker in the space or start state reach the keyword matcher
    if (cm_d == CM_SPACE || cm_d == CM_START) begin
      case (kw)
        KW_CODE: begin
          if (c == "b") begin
            kw_d = KW_BEGIN; idx_d = 4'd1;
          end else if (c == "e") begin
            kw_d = KW_END; idx_d = 4'd1;
          end else if (c == "f") begin
            kw_d = KW_FUNC; idx_d = 4'd1;
          end else if (c == "p") begin
            kw_d = KW_PROC; idx_d = 4'd1;
          end
        end
        KW_PROC, KW_FUNC, KW_BEGIN, KW_END: begin
          if (idx_q < kw_len(kw) && c == kw_char(kw, idx_q)) begin
            if (idx_q + 4'd1 == kw_len(kw)) begin
              idx_d = 4'd0;
              case (kw)
                KW_BEGIN: begin
                  kw_d = KW_CODE;
                  if (bd < DW'(DEPTH_MAX)) bdepth_d = bd + DW'(1);
                end
                KW_END: begin
                  kw_d = KW_CODE;
                  if (bd != '0) begin
                    bdepth_d = bd_dec;
                    if ($signed({1'b0, bd_dec}) == rd) begin
                      out_d.routine_end = 1'b1;
                      rdepth_d          = rd - RW'(1);
                    end
                  end
                end
                default: kw_d = KW_SPACE;
              endcase
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end else begin
            kw_d = KW_CODE;
          end
        end
        KW_SPACE: begin
          if (!is_sp) begin
            if (is_al) begin
              nlen_d          = NW'(1);
              out_d.name_char = 1'b1;
              sstart_d        = in_q.char_position;
              spage_d         = in_q.page;
              kw_d            = KW_NAME;
            end else begin
              kw_d = KW_CODE;
            end
          end
        end
        KW_NAME: begin
          if ((is_an || c == CH_UNDER) && nlen_q < NW'(NAME_MAX - 1)) begin
            nlen_d          = nlen_q + NW'(1);
            out_d.name_char = 1'b1;
          end else begin
            out_d.name_done  = 1'b1;
            out_d.name_start = sstart_q;
            out_d.name_end   = in_q.char_position - 32'd1;
            out_d.name_page  = spage_q;
            kw_d             = KW_CODE;
            rdepth_d         = $signed({1'b0, bd});
          end
        end
        default: kw_d = KW_CODE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cm_q        <= CM_SPACE;
      kw_q        <= KW_CODE;
      idx_q       <= '0;
      nlen_q      <= '0;
      sstart_q    <= '0;
      spage_q     <= '0;
      bdepth_q    <= '0;
      rdepth_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (step) begin
        cm_q     <= cm_d;
        kw_q     <= kw_d;
        idx_q    <= idx_d;
        nlen_q   <= nlen_d;
        sstart_q <= sstart_d;
        spage_q  <= spage_d;
        bdepth_q <= bdepth_d;
        rdepth_q <= rdepth_d;
      end
    end
  end

  // Payload registers: input loads on handshake, result loads on step, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q      <= in_beat_t'(s_axis_tdata);
      restart_q <= s_axis_tuser;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

`include "pascal_comment_and_routine_scanner_assert.svh"

  `PCRS_ASSERT_EXCL(a_name_flags_excl, m_axis_tvalid && out_q.name_done, out_q.name_char)
  `PCRS_ASSERT_EXCL(a_end_vs_name, m_axis_tvalid && out_q.routine_end, out_q.name_done)
  `PCRS_ASSERT_IMPL(a_depth_bound, 1'b1, bdepth_q <= DW'(DEPTH_MAX))
  `PCRS_ASSERT_IMPL(a_rdepth_floor, 1'b1, rdepth_q >= -$signed(RW'(1)))

endmodule
